>>> rtl/lsplex_pkg.sv
// ----------------------------------------------------------------------------
// lsplex_pkg
// Shared types and constants of the Lisp token lexer: scanner modes, token
// kinds, character codes and the token record passed to the output queue.
// ----------------------------------------------------------------------------
package lsplex_pkg;

  // Widths of the position counters and of the token fields.
  localparam int OFF_W   = 21;              // byte offset, saturates at TEXT_BYTES
  localparam int TOFF_W  = 20;              // offset as reported in a token
  localparam int LEN_W   = 21;
  localparam int LINE_W  = 16;
  localparam int COL_W   = 16;

  localparam logic [OFF_W-1:0]  TEXT_BYTES = OFF_W'(1 << 20);
  localparam logic [LINE_W-1:0] LINE_MAX   = '1;
  localparam logic [COL_W-1:0]  COL_MAX    = '1;

  // Depth of the result queue and the width of its fill count.
  localparam int OQ_DEPTH = 4;
  localparam int OQ_CNT_W = $clog2(OQ_DEPTH + 1);

  // Character codes the scanner looks at.
  localparam logic [7:0] CH_NUL   = 8'h00;
  localparam logic [7:0] CH_TAB   = 8'h09;
  localparam logic [7:0] CH_LF    = 8'h0A;
  localparam logic [7:0] CH_CR    = 8'h0D;
  localparam logic [7:0] CH_SPACE = 8'h20;
  localparam logic [7:0] CH_DQUOTE = 8'h22;
  localparam logic [7:0] CH_SQUOTE = 8'h27;
  localparam logic [7:0] CH_LPAREN = 8'h28;
  localparam logic [7:0] CH_RPAREN = 8'h29;
  localparam logic [7:0] CH_COMMA = 8'h2C;
  localparam logic [7:0] CH_MINUS = 8'h2D;
  localparam logic [7:0] CH_DOT   = 8'h2E;
  localparam logic [7:0] CH_0     = 8'h30;
  localparam logic [7:0] CH_9     = 8'h39;
  localparam logic [7:0] CH_SEMI  = 8'h3B;
  localparam logic [7:0] CH_AT    = 8'h40;
  localparam logic [7:0] CH_BTICK = 8'h60;

  // Scanner mode: what kind of token is open, if any.
  typedef enum logic [7:0] {
    MODE_IDLE  = 8'b0000_0001,
    MODE_INT   = 8'b0000_0010,
    MODE_FRAC  = 8'b0000_0100,
    MODE_STR   = 8'b0000_1000,
    MODE_SYM   = 8'b0001_0000,
    MODE_CMT   = 8'b0010_0000,
    MODE_MINUS = 8'b0100_0000,
    MODE_COMMA = 8'b1000_0000
  } mode_t;

  // Token kind as reported on the result channel.
  typedef enum logic [3:0] {
    KIND_EOF    = 4'd0,
    KIND_NUM    = 4'd1,
    KIND_STR    = 4'd2,
    KIND_SYM    = 4'd3,
    KIND_OPEN   = 4'd4,
    KIND_CLOSE  = 4'd5,
    KIND_UNQ    = 4'd6,
    KIND_QQ     = 4'd7,
    KIND_QUOTE  = 4'd8,
    KIND_SPLICE = 4'd9,
    KIND_PERIOD = 4'd10
  } kind_t;

  // One result item.
  typedef struct packed {
    kind_t              kind;
    logic [TOFF_W-1:0]  offset;
    logic [LEN_W-1:0]   length;
    logic [LINE_W-1:0]  line;
    logic [COL_W-1:0]   column;
    logic               unterm;
    logic               last;
  } tok_t;

  // The results of one byte: up to two tokens, in delivery order.
  typedef struct packed {
    logic [1:0] cnt;
    tok_t       t0;
    tok_t       t1;
  } tok_pair_t;

endpackage

>>> rtl/lisp_token_lexer.sv
// ----------------------------------------------------------------------------
// lisp_token_lexer
// Streaming Lisp s-expression lexer: one source byte in per beat, tokens out
// with kind, offset, length, line and column.
// ----------------------------------------------------------------------------
// The lexer takes one source byte per clock cycle and passes each byte
// through the input register, then the scanner logic into the result queue.
// A byte that both closes a token and forms one on its own yields two
// result beats, and the result port delivers one beat per cycle while
// out_tready is high, so a stream of such bytes is limited by the output
// side; the four-entry result queue stalls in_tready when it cannot hold
// two more tokens. A zero byte ends the text: any open token is flushed,
// an eof token follows, and line, column and offset restart at 1, 1 and 0.
// tlast marks the last token caused by one byte. After reset the lexer is
// between tokens at offset 0, line 1, column 1.
module lisp_token_lexer (
  input  logic        clk,
  input  logic        rst_n,
  // Source bytes.
  input  logic        in_tvalid,
  output logic        in_tready,
  input  logic [7:0]  in_tdata,   // [7:0] text_byte
  // Tokens.
  output logic        out_tvalid,
  input  logic        out_tready,
  output logic [79:0] out_tdata,  // [19:0] token_offset, [40:20] token_length,
                                  // [56:41] token_line, [72:57] token_column,
                                  // [79:73] zero
  output logic [4:0]  out_tuser,  // [3:0] token_kind, [4] unterminated
  output logic        out_tlast   // last_of_run
);
  import lsplex_pkg::*;

  logic       s1_valid_r, s1_valid_nxt;
  logic [7:0] s1_byte_r;
  logic       in_fire;
  logic       step;
  logic       room;
  tok_pair_t  res;
  tok_t       head;

  // Input register; the scanner takes its byte when the queue has room.
  assign in_fire   = in_tvalid && in_tready;
  assign step      = s1_valid_r && room;
  assign in_tready = !s1_valid_r || step;

  always_comb begin
    s1_valid_nxt = s1_valid_r;
    if (in_fire) begin
      s1_valid_nxt = 1'b1;
    end else if (step) begin
      s1_valid_nxt = 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s1_valid_r <= 1'b0;
    end else begin
      s1_valid_r <= s1_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (in_fire) begin
      s1_byte_r <= in_tdata;
    end
  end

  // Scanner state and token formation.
  lsplex_scan u_scan (
    .clk       (clk),
    .rst_n     (rst_n),
    .step      (step),
    .text_byte (s1_byte_r),
    .res       (res)
  );

  // Result queue.
  lsplex_outq u_outq (
    .clk        (clk),
    .rst_n      (rst_n),
    .push       (step),
    .push_data  (res),
    .room       (room),
    .head_valid (out_tvalid),
    .head       (head),
    .pop_ready  (out_tready)
  );

  // Pack the head token onto the stream.
  assign out_tdata = {7'b0, head.column, head.line, head.length, head.offset};
  assign out_tuser = {head.unterm, head.kind};
  assign out_tlast = head.last;

`ifndef SYNTHESIS
  // A zero byte always produces at least the eof token.
  a_eof_emitted: assert property (@(posedge clk) disable iff (!rst_n)
    (step && (s1_byte_r == CH_NUL)) |-> (res.cnt != 2'd0))
    else $error("end of text produced no token");

  // Only the final token of a byte carries tlast.
  a_last_pair: assert property (@(posedge clk) disable iff (!rst_n)
    (step && (res.cnt == 2'd2)) |-> (!res.t0.last && res.t1.last))
    else $error("two-token byte has wrong last marks");

  a_last_single: assert property (@(posedge clk) disable iff (!rst_n)
    (step && (res.cnt == 2'd1)) |-> res.t0.last)
    else $error("single token not marked last");

  // A zero byte returns the scanner to offset 0, line 1 and column 1 for the next token.
  a_eof_restart: assert property (@(posedge clk) disable iff (!rst_n)
    (step && (s1_byte_r == CH_NUL)) |=>
      (!step || (res.t0.kind != KIND_EOF) || (res.t0.offset == '0)))
    else $error("position not restarted after end of text");
`endif

endmodule

>>> rtl/lsplex_scan.sv
// ----------------------------------------------------------------------------
// lsplex_scan
// Token scanner: holds the scan mode and position counters and turns one
// source byte into zero, one or two finished tokens.
// ----------------------------------------------------------------------------
module lsplex_scan (
  input  logic                  clk,
  input  logic                  rst_n,
  input  logic                  step,
  input  logic [7:0]            text_byte,
  output lsplex_pkg::tok_pair_t res
);
  import lsplex_pkg::*;

  mode_t              mode_r, mode_nxt;
  logic [OFF_W-1:0]   off_r, off_nxt;
  logic [LINE_W-1:0]  line_r, line_nxt;
  logic [COL_W-1:0]   col_r, col_nxt;
  logic [OFF_W-1:0]   open_off_r, open_off_nxt;
  logic [LINE_W-1:0]  open_line_r, open_line_nxt;
  logic [COL_W-1:0]   open_col_r, open_col_nxt;

  logic               is_ws, is_dig, ends_sym;
  logic [LEN_W-1:0]   len;

  // Outcome of a byte seen between tokens.
  mode_t              id_mode;
  logic               id_open;
  logic               id_here;
  kind_t              id_kind;

  // Token closed by this byte, and token made by this byte alone.
  logic               take_idle;
  logic               emit_open;
  kind_t              open_kind;
  logic [LEN_W-1:0]   open_len;
  logic               open_unt;
  logic               emit_here;
  kind_t              here_kind;
  logic [LEN_W-1:0]   here_len;
  logic               here_unt;
  tok_t               open_tok, here_tok;

  // Character classes.
  always_comb begin
    is_ws  = (text_byte == CH_SPACE) || (text_byte == CH_LF) ||
             (text_byte == CH_TAB) || (text_byte == CH_CR);
    is_dig = (text_byte >= CH_0) && (text_byte <= CH_9);
    ends_sym = is_ws || (text_byte == CH_LPAREN) || (text_byte == CH_RPAREN) ||
               (text_byte == CH_NUL) || (text_byte == CH_SEMI) ||
               (text_byte == CH_DQUOTE) || (text_byte == CH_SQUOTE) ||
               (text_byte == CH_BTICK) || (text_byte == CH_COMMA);
  end

  // Decode of a byte that arrives with no token open.
  always_comb begin
    id_mode = MODE_IDLE;
    id_open = 1'b0;
    id_here = 1'b0;
    id_kind = KIND_OPEN;
    if (!is_ws) begin
      case (text_byte)
        CH_SEMI:   id_mode = MODE_CMT;
        CH_MINUS:  begin id_mode = MODE_MINUS; id_open = 1'b1; end
        CH_DQUOTE: begin id_mode = MODE_STR;   id_open = 1'b1; end
        CH_COMMA:  begin id_mode = MODE_COMMA; id_open = 1'b1; end
        CH_LPAREN: begin id_here = 1'b1; id_kind = KIND_OPEN;   end
        CH_RPAREN: begin id_here = 1'b1; id_kind = KIND_CLOSE;  end
        CH_DOT:    begin id_here = 1'b1; id_kind = KIND_PERIOD; end
        CH_BTICK:  begin id_here = 1'b1; id_kind = KIND_QQ;     end
        CH_SQUOTE: begin id_here = 1'b1; id_kind = KIND_QUOTE;  end
        default: begin
          id_mode = is_dig ? MODE_INT : MODE_SYM;
          id_open = 1'b1;
        end
      endcase
    end
  end

  // Mode transitions, token emission and position bookkeeping.
  always_comb begin
    len           = off_r - open_off_r;
    mode_nxt      = mode_r;
    off_nxt       = off_r;
    line_nxt      = line_r;
    col_nxt       = col_r;
    open_off_nxt  = open_off_r;
    open_line_nxt = open_line_r;
    open_col_nxt  = open_col_r;
    take_idle     = 1'b0;
    emit_open     = 1'b0;
    open_kind     = KIND_SYM;
    open_len      = len;
    open_unt      = 1'b0;
    emit_here     = 1'b0;
    here_kind     = KIND_EOF;
    here_len      = LEN_W'(1);
    here_unt      = 1'b0;

    if (text_byte == CH_NUL) begin
      // End of text: flush the open token, then report eof and start over.
      unique case (mode_r)
        MODE_INT, MODE_FRAC: begin emit_open = 1'b1; open_kind = KIND_NUM; end
        MODE_SYM, MODE_MINUS: begin emit_open = 1'b1; open_kind = KIND_SYM; end
        MODE_COMMA: begin
          emit_open = 1'b1;
          open_kind = KIND_UNQ;
          open_len  = LEN_W'(1);
        end
        MODE_STR: begin
          emit_open = 1'b1;
          open_kind = KIND_STR;
          open_unt  = 1'b1;
          here_unt  = 1'b1;
        end
        MODE_CMT: here_unt = 1'b1;
        default: ;
      endcase
      emit_here     = 1'b1;
      here_kind     = KIND_EOF;
      here_len      = '0;
      mode_nxt      = MODE_IDLE;
      off_nxt       = '0;
      line_nxt      = LINE_W'(1);
      col_nxt       = COL_W'(1);
      open_off_nxt  = '0;
      open_line_nxt = LINE_W'(1);
      open_col_nxt  = COL_W'(1);
    end else begin
      unique case (mode_r)
        MODE_INT: begin
          if (text_byte == CH_DOT) begin
            mode_nxt = MODE_FRAC;
          end else if (!is_dig) begin
            emit_open = 1'b1;
            open_kind = KIND_NUM;
            take_idle = 1'b1;
          end
        end
        MODE_FRAC: begin
          if (!is_dig) begin
            emit_open = 1'b1;
            open_kind = KIND_NUM;
            take_idle = 1'b1;
          end
        end
        MODE_STR: begin
          if (text_byte == CH_DQUOTE) begin
            emit_open = 1'b1;
            open_kind = KIND_STR;
            open_len  = len + LEN_W'(1);
            mode_nxt  = MODE_IDLE;
          end
        end
        MODE_SYM: begin
          if (ends_sym) begin
            emit_open = 1'b1;
            open_kind = KIND_SYM;
            take_idle = 1'b1;
          end
        end
        MODE_CMT: begin
          if (text_byte == CH_LF) begin
            mode_nxt = MODE_IDLE;
          end
        end
        MODE_MINUS: begin
          if (is_dig) begin
            mode_nxt = MODE_INT;
          end else if (ends_sym) begin
            emit_open = 1'b1;
            open_kind = KIND_SYM;
            open_len  = LEN_W'(1);
            take_idle = 1'b1;
          end else begin
            mode_nxt = MODE_SYM;
          end
        end
        MODE_COMMA: begin
          emit_open = 1'b1;
          if (text_byte == CH_AT) begin
            open_kind = KIND_SPLICE;
            open_len  = LEN_W'(2);
            mode_nxt  = MODE_IDLE;
          end else begin
            open_kind = KIND_UNQ;
            open_len  = LEN_W'(1);
            take_idle = 1'b1;
          end
        end
        default: take_idle = 1'b1;
      endcase

      // The byte is lexed afresh once the open token is closed.
      if (take_idle) begin
        mode_nxt  = id_mode;
        emit_here = id_here;
        here_kind = id_kind;
        if (id_open) begin
          open_off_nxt  = off_r;
          open_line_nxt = line_r;
          open_col_nxt  = col_r;
        end
      end

      // Advance the position; offset, line and column saturate.
      if (off_r < TEXT_BYTES) begin
        off_nxt = off_r + OFF_W'(1);
      end
      if (text_byte == CH_LF) begin
        if (line_r != LINE_MAX) begin
          line_nxt = line_r + LINE_W'(1);
        end
        col_nxt = COL_W'(1);
      end else if (col_r != COL_MAX) begin
        col_nxt = col_r + COL_W'(1);
      end
    end
  end

  // Assemble the result pair; the closed token always goes first.
  always_comb begin
    open_tok.kind   = open_kind;
    open_tok.offset = open_off_r[TOFF_W-1:0];
    open_tok.length = open_len;
    open_tok.line   = open_line_r;
    open_tok.column = open_col_r;
    open_tok.unterm = open_unt;
    open_tok.last   = !emit_here;

    here_tok.kind   = here_kind;
    here_tok.offset = off_r[TOFF_W-1:0];
    here_tok.length = here_len;
    here_tok.line   = line_r;
    here_tok.column = col_r;
    here_tok.unterm = here_unt;
    here_tok.last   = 1'b1;

    res.cnt = {1'b0, emit_open} + {1'b0, emit_here};
    res.t0  = emit_open ? open_tok : here_tok;
    res.t1  = here_tok;
  end

  // State registers advance only when a byte is taken.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      mode_r      <= MODE_IDLE;
      off_r       <= '0;
      line_r      <= LINE_W'(1);
      col_r       <= COL_W'(1);
      open_off_r  <= '0;
      open_line_r <= LINE_W'(1);
      open_col_r  <= COL_W'(1);
    end else if (step) begin
      mode_r      <= mode_nxt;
      off_r       <= off_nxt;
      line_r      <= line_nxt;
      col_r       <= col_nxt;
      open_off_r  <= open_off_nxt;
      open_line_r <= open_line_nxt;
      open_col_r  <= open_col_nxt;
    end
  end

endmodule

>>> rtl/lsplex_outq.sv
// ----------------------------------------------------------------------------
// lsplex_outq
// Result queue: a short shifting queue of tokens, written with up to two
// tokens per cycle and read one token per beat from its head.
// ----------------------------------------------------------------------------
module lsplex_outq (
  input  logic                  clk,
  input  logic                  rst_n,
  input  logic                  push,
  input  lsplex_pkg::tok_pair_t push_data,
  output logic                  room,
  output logic                  head_valid,
  output lsplex_pkg::tok_t      head,
  input  logic                  pop_ready
);
  import lsplex_pkg::*;

  tok_t                q_r   [OQ_DEPTH];
  tok_t                q_nxt [OQ_DEPTH];
  logic [OQ_CNT_W-1:0] cnt_r, cnt_nxt;
  logic [OQ_CNT_W-1:0] base, base1;
  logic [1:0]          n_push;
  logic                pop;

  assign head_valid = (cnt_r != '0);
  assign head       = q_r[0];
  assign pop        = head_valid && pop_ready;
  // Room for the worst case of two tokens from one byte.
  assign room       = (cnt_r <= OQ_CNT_W'(OQ_DEPTH - 2));

  // Shift on a pop, then append the new tokens behind what remains.
  always_comb begin
    n_push  = push ? push_data.cnt : 2'd0;
    base    = cnt_r - {{(OQ_CNT_W-1){1'b0}}, pop};
    base1   = base + OQ_CNT_W'(1);
    cnt_nxt = base + OQ_CNT_W'(n_push);
    for (int i = 0; i < OQ_DEPTH; i++) begin
      q_nxt[i] = (pop && (i < OQ_DEPTH - 1)) ? q_r[(i < OQ_DEPTH - 1) ? i + 1 : i] : q_r[i];
      if ((n_push != 2'd0) && (OQ_CNT_W'(i) == base)) begin
        q_nxt[i] = push_data.t0;
      end
      if ((n_push == 2'd2) && (OQ_CNT_W'(i) == base1)) begin
        q_nxt[i] = push_data.t1;
      end
    end
  end

  // Fill count.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cnt_r <= '0;
    end else begin
      cnt_r <= cnt_nxt;
    end
  end

  // Queue entries carry payload only.
  always_ff @(posedge clk) begin
    for (int i = 0; i < OQ_DEPTH; i++) begin
      q_r[i] <= q_nxt[i];
    end
  end

endmodule

>>> sim/lisp_token_lexer_tb.sv
// ----------------------------------------------------------------------------
// lisp_token_lexer_tb
// Self-checking bench for the Lisp token lexer. Source text is streamed in
// one byte per beat with random gaps, and the token side is randomly
// back-pressured. A scoreboard runs its own scanner over every accepted byte
// and checks each token beat field by field against what it predicted.
// ----------------------------------------------------------------------------
module lisp_token_lexer_tb;
  timeunit 1ns;
  timeprecision 1ps;

  import lsplex_pkg::*;

  localparam int IDLE_LIMIT   = 20000;        // cycles without any beat
  localparam int RANDOM_BYTES = 960;
  localparam int SHOWN_ERRORS = 40;

  // Token scoreboard: predicts the tokens of each byte and checks the beats.
  class lex_scoreboard;
    tok_t              queued_tokens[$];
    tok_t              step_tokens[$];
    mode_t             lex_mode;
    logic [OFF_W-1:0]  pos;
    logic [OFF_W-1:0]  tok_start;
    logic [LINE_W-1:0] cur_line;
    logic [LINE_W-1:0] tok_line;
    logic [COL_W-1:0]  cur_col;
    logic [COL_W-1:0]  tok_col;
    int                errors;
    int                checked;
    int                kind_hits[11];

    function new();
      restart();
      errors  = 0;
      checked = 0;
      foreach (kind_hits[i]) kind_hits[i] = 0;
    endfunction

    // State between texts: no token open, back at the first byte.
    function void restart();
      lex_mode  = MODE_IDLE;
      pos       = '0;
      tok_start = '0;
      cur_line  = 1;
      tok_line  = 1;
      cur_col   = 1;
      tok_col   = 1;
    endfunction

    function bit is_space(logic [7:0] c);
      return c == CH_SPACE || c == CH_LF || c == CH_TAB || c == CH_CR;
    endfunction

    function bit is_numeral(logic [7:0] c);
      return c >= CH_0 && c <= CH_9;
    endfunction

    function bit closes_symbol(logic [7:0] c);
      return is_space(c) || c == CH_LPAREN || c == CH_RPAREN || c == CH_NUL ||
             c == CH_SEMI || c == CH_DQUOTE || c == CH_SQUOTE || c == CH_BTICK ||
             c == CH_COMMA;
    endfunction

    function void emit(kind_t kind, logic [OFF_W-1:0] off, logic [LEN_W-1:0] len,
                       logic [LINE_W-1:0] ln, logic [COL_W-1:0] col, logic unterm);
      tok_t t;
      t.kind   = kind;
      t.offset = off[TOFF_W-1:0];
      t.length = len;
      t.line   = ln;
      t.column = col;
      t.unterm = unterm;
      t.last   = 1'b0;
      step_tokens.push_back(t);
    endfunction

    // Token that started earlier and is closed now.
    function void emit_open(kind_t kind, logic [LEN_W-1:0] len, logic unterm);
      emit(kind, tok_start, len, tok_line, tok_col, unterm);
    endfunction

    // Single-byte token at the current position.
    function void emit_here(kind_t kind);
      emit(kind, pos, 1, cur_line, cur_col, 1'b0);
    endfunction

    function void open_token(mode_t m);
      tok_start = pos;
      tok_line  = cur_line;
      tok_col   = cur_col;
      lex_mode  = m;
    endfunction

    // A byte seen while no token is open.
    function void lex_idle(logic [7:0] c);
      lex_mode = MODE_IDLE;
      if (!is_space(c)) begin
        case (c)
          CH_SEMI:   lex_mode = MODE_CMT;
          CH_MINUS:  open_token(MODE_MINUS);
          CH_DQUOTE: open_token(MODE_STR);
          CH_COMMA:  open_token(MODE_COMMA);
          CH_LPAREN: emit_here(KIND_OPEN);
          CH_RPAREN: emit_here(KIND_CLOSE);
          CH_DOT:    emit_here(KIND_PERIOD);
          CH_BTICK:  emit_here(KIND_QQ);
          CH_SQUOTE: emit_here(KIND_QUOTE);
          default: begin
            if (is_numeral(c)) open_token(MODE_INT);
            else open_token(MODE_SYM);
          end
        endcase
      end
    endfunction

    // Runs one accepted source byte through the scanner and queues its tokens.
    function void lex_byte(logic [7:0] c);
      logic [LEN_W-1:0] span;
      logic             unterm;
      tok_t             t;
      span   = pos - tok_start;
      unterm = 1'b0;
      step_tokens.delete();
      if (c == CH_NUL) begin
        // End of text: flush whatever is open, then eof at this byte.
        case (lex_mode)
          MODE_INT, MODE_FRAC:  emit_open(KIND_NUM, span, 1'b0);
          MODE_SYM, MODE_MINUS: emit_open(KIND_SYM, span, 1'b0);
          MODE_COMMA:           emit_open(KIND_UNQ, 1, 1'b0);
          MODE_STR: begin
            unterm = 1'b1;
            emit_open(KIND_STR, span, 1'b1);
          end
          MODE_CMT:             unterm = 1'b1;
          default: ;
        endcase
        emit(KIND_EOF, pos, '0, cur_line, cur_col, unterm);
        restart();
      end else begin
        case (lex_mode)
          MODE_INT: begin
            if (c == CH_DOT) begin
              lex_mode = MODE_FRAC;
            end else if (!is_numeral(c)) begin
              emit_open(KIND_NUM, span, 1'b0);
              lex_idle(c);
            end
          end
          MODE_FRAC: begin
            if (!is_numeral(c)) begin
              emit_open(KIND_NUM, span, 1'b0);
              lex_idle(c);
            end
          end
          MODE_STR: begin
            if (c == CH_DQUOTE) begin
              emit_open(KIND_STR, span + LEN_W'(1), 1'b0);
              lex_mode = MODE_IDLE;
            end
          end
          MODE_SYM: begin
            if (closes_symbol(c)) begin
              emit_open(KIND_SYM, span, 1'b0);
              lex_idle(c);
            end
          end
          MODE_CMT: begin
            if (c == CH_LF) lex_mode = MODE_IDLE;
          end
          MODE_MINUS: begin
            if (is_numeral(c)) begin
              lex_mode = MODE_INT;
            end else if (closes_symbol(c)) begin
              emit_open(KIND_SYM, 1, 1'b0);
              lex_idle(c);
            end else begin
              lex_mode = MODE_SYM;
            end
          end
          MODE_COMMA: begin
            if (c == CH_AT) begin
              emit_open(KIND_SPLICE, 2, 1'b0);
              lex_mode = MODE_IDLE;
            end else begin
              emit_open(KIND_UNQ, 1, 1'b0);
              lex_idle(c);
            end
          end
          default: lex_idle(c);
        endcase
        // Position bookkeeping, all counters saturating.
        if (pos < TEXT_BYTES) pos++;
        if (c == CH_LF) begin
          if (cur_line < LINE_MAX) cur_line++;
          cur_col = 1;
        end else if (cur_col < COL_MAX) begin
          cur_col++;
        end
      end
      // The final token of this byte carries tlast.
      if (step_tokens.size() > 0) begin
        t = step_tokens.pop_back();
        t.last = 1'b1;
        step_tokens.push_back(t);
      end
      foreach (step_tokens[i]) queued_tokens.push_back(step_tokens[i]);
    endfunction

    function int pending();
      return queued_tokens.size();
    endfunction

    function int kinds_seen();
      int n;
      n = 0;
      foreach (kind_hits[i]) if (kind_hits[i] > 0) n++;
      return n;
    endfunction

    function void report(string field, longint want, longint got);
      errors++;
      if (errors <= SHOWN_ERRORS)
        $display("%0t: %s mismatch, expected %0d, actual %0d", $time, field, want, got);
    endfunction

    // Compares one token beat with the oldest prediction.
    function void match_token(tok_t got);
      tok_t want;
      checked++;
      if (queued_tokens.size() == 0) begin
        errors++;
        if (errors <= SHOWN_ERRORS)
          $display("%0t: unexpected token, expected none, actual kind %0d offset %0d",
                   $time, got.kind, got.offset);
        return;
      end
      want = queued_tokens.pop_front();
      kind_hits[want.kind]++;
      if (got.kind !== want.kind)     report("token_kind", want.kind, got.kind);
      if (got.offset !== want.offset) report("token_offset", want.offset, got.offset);
      if (got.length !== want.length) report("token_length", want.length, got.length);
      if (got.line !== want.line)     report("token_line", want.line, got.line);
      if (got.column !== want.column) report("token_column", want.column, got.column);
      if (got.unterm !== want.unterm) report("unterminated", want.unterm, got.unterm);
      if (got.last !== want.last)     report("last_of_run", want.last, got.last);
    endfunction
  endclass

  logic        clk        = 1'b0;
  logic        rst_n      = 1'b0;
  logic        in_tvalid  = 1'b0;
  logic        in_tready;
  logic [7:0]  in_tdata   = '0;
  logic        out_tvalid;
  logic        out_tready = 1'b0;
  logic [79:0] out_tdata;
  logic [4:0]  out_tuser;
  logic        out_tlast;

  lex_scoreboard sb = new();
  logic [7:0]    text_q[$];
  bit            calm = 1'b1;      // no gaps on either side while set
  int            bytes_taken = 0;
  int            quiet_cycles = 0;

  always #5 clk = ~clk;

  lisp_token_lexer dut (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_tvalid  (in_tvalid),
    .in_tready  (in_tready),
    .in_tdata   (in_tdata),
    .out_tvalid (out_tvalid),
    .out_tready (out_tready),
    .out_tdata  (out_tdata),
    .out_tuser  (out_tuser),
    .out_tlast  (out_tlast)
  );

  // Mostly back-to-back, sometimes a short gap, rarely a long pause.
  function automatic int pick_gap();
    int r;
    r = $urandom_range(0, 99);
    if (calm || r < 70) return 0;
    if (r < 94) return $urandom_range(1, 3);
    return $urandom_range(8, 40);
  endfunction

  // Beat monitor: feeds accepted bytes to the scoreboard, checks token beats
  // and ends the run if the handshakes stop moving.
  always @(posedge clk) begin : beat_monitor
    tok_t got;
    if (rst_n && out_tvalid && out_tready) begin
      got.kind   = kind_t'(out_tuser[3:0]);
      got.unterm = out_tuser[4];
      got.offset = out_tdata[19:0];
      got.length = out_tdata[40:20];
      got.line   = out_tdata[56:41];
      got.column = out_tdata[72:57];
      got.last   = out_tlast;
      sb.match_token(got);
    end
    if (rst_n && in_tvalid && in_tready) begin
      sb.lex_byte(in_tdata);
      bytes_taken++;
    end
    if (!rst_n || (out_tvalid && out_tready) || (in_tvalid && in_tready)) begin
      quiet_cycles = 0;
    end else begin
      quiet_cycles++;
      if (quiet_cycles >= IDLE_LIMIT) begin
        $display("%0t: no beat for %0d cycles, %0d tokens outstanding",
                 $time, quiet_cycles, sb.pending());
        $display("[FAIL] regression broken");
        $finish;
      end
    end
  end

  // Token sink with random back-pressure.
  initial begin : token_sink
    int gap;
    @(posedge clk);
    while (!rst_n) @(posedge clk);
    forever begin
      out_tready <= 1'b1;
      repeat ($urandom_range(1, 12)) @(posedge clk);
      gap = pick_gap();
      if (gap > 0) begin
        out_tready <= 1'b0;
        repeat (gap) @(posedge clk);
      end
    end
  end

  // Presents one byte, holds it until accepted, then maybe idles.
  task automatic send_byte(input logic [7:0] b);
    int gap;
    in_tvalid <= 1'b1;
    in_tdata  <= b;
    do @(posedge clk); while (!in_tready);
    gap = pick_gap();
    if (gap > 0) begin
      in_tvalid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
  endtask

  task automatic send_text(input string s);
    for (int i = 0; i < s.len(); i++) send_byte(s[i]);
  endtask

  // Stops feeding bytes until every predicted token has come out.
  task automatic hold_until_drained();
    in_tvalid <= 1'b0;
    @(posedge clk);
    while (sb.pending() != 0) @(posedge clk);
  endtask

  function automatic logic [7:0] pick_space();
    case ($urandom_range(0, 3))
      0:       return CH_SPACE;
      1:       return CH_TAB;
      2:       return CH_CR;
      default: return CH_LF;
    endcase
  endfunction

  // A byte that may sit inside a symbol without ending it.
  function automatic logic [7:0] pick_sym_char();
    logic [7:0] punct[11] = '{"*", "+", "!", "?", "<", "=", ">", "/", CH_AT, CH_DOT,
                              CH_MINUS};
    int r;
    r = $urandom_range(0, 99);
    if (r < 50) return 8'($urandom_range(8'h61, 8'h7a));
    if (r < 62) return 8'($urandom_range(CH_0, CH_9));
    if (r < 80) return punct[$urandom_range(0, 10)];
    return 8'($urandom_range(8'h80, 8'hff));
  endfunction

  // Appends one random piece of source text, mostly well formed.
  function automatic void build_fragment();
    int         r;
    logic [7:0] b;
    r = $urandom_range(0, 99);
    if (r < 14) begin
      // Number: optional minus, digits, optional fraction, rarely a second dot.
      if ($urandom_range(0, 3) == 0) text_q.push_back(CH_MINUS);
      repeat ($urandom_range(1, 4)) text_q.push_back(8'($urandom_range(CH_0, CH_9)));
      if ($urandom_range(0, 1) == 1) begin
        text_q.push_back(CH_DOT);
        repeat ($urandom_range(0, 3)) text_q.push_back(8'($urandom_range(CH_0, CH_9)));
        if ($urandom_range(0, 5) == 0) text_q.push_back(CH_DOT);
      end
    end else if (r < 26) begin
      text_q.push_back(8'($urandom_range(8'h61, 8'h7a)));
      repeat ($urandom_range(0, 5)) text_q.push_back(pick_sym_char());
    end else if (r < 34) begin
      // String; now and then the closing quote is left off.
      text_q.push_back(CH_DQUOTE);
      repeat ($urandom_range(0, 6)) begin
        b = 8'($urandom_range(1, 255));
        text_q.push_back(b == CH_DQUOTE ? CH_LF : b);
      end
      if ($urandom_range(0, 9) != 0) text_q.push_back(CH_DQUOTE);
    end else if (r < 44) begin
      text_q.push_back($urandom_range(0, 1) ? CH_LPAREN : CH_RPAREN);
    end else if (r < 54) begin
      case ($urandom_range(0, 3))
        0: text_q.push_back(CH_SQUOTE);
        1: text_q.push_back(CH_BTICK);
        2: text_q.push_back(CH_COMMA);
        default: begin
          text_q.push_back(CH_COMMA);
          text_q.push_back(CH_AT);
        end
      endcase
    end else if (r < 58) begin
      text_q.push_back(CH_DOT);
    end else if (r < 63) begin
      // Comment, usually closed by a line feed.
      text_q.push_back(CH_SEMI);
      repeat ($urandom_range(0, 8)) begin
        b = 8'($urandom_range(1, 255));
        text_q.push_back(b == CH_LF ? CH_SPACE : b);
      end
      if ($urandom_range(0, 9) != 0) text_q.push_back(CH_LF);
    end else if (r < 68) begin
      text_q.push_back(CH_MINUS);
    end else if (r < 72) begin
      text_q.push_back(CH_NUL);
    end else if (r < 90) begin
      repeat ($urandom_range(1, 3)) text_q.push_back(pick_space());
    end else begin
      repeat ($urandom_range(1, 3)) text_q.push_back(8'($urandom_range(0, 255)));
    end
    // Usually a separator, sometimes tokens run into each other.
    if ($urandom_range(0, 9) < 7) text_q.push_back(pick_space());
  endfunction

  initial begin : stimulus
    int  random_sent;
    bit  drained;
    random_sent = 0;
    drained     = 1'b0;
    repeat (6) @(posedge clk);
    rst_n <= 1'b1;

    // Directed text: every token kind, negative and fractional numbers, a
    // second dot, a byte that closes one token and forms another, tab and CR
    // inside a comment, a top byte value and a string cut off by end of text.
    send_text("(-7 1.2.,@x,'");
    send_byte(CH_BTICK);
    send_text("- ;\t\015\n)\377\"a");
    send_byte(CH_NUL);
    // Minus starting a symbol, a closed string, a number ending in a dot and
    // a comment cut off by end of text.
    send_text("-x\"s\"1.;\001");
    send_byte(CH_NUL);
    hold_until_drained();

    // Random text with gaps, stretches of full rate and one drain midway.
    while (random_sent < RANDOM_BYTES) begin
      calm = (random_sent % 300) < 60;
      if (!drained && random_sent >= RANDOM_BYTES / 2) begin
        hold_until_drained();
        drained = 1'b1;
      end
      build_fragment();
      while (text_q.size() > 0) begin
        send_byte(text_q.pop_front());
        random_sent++;
      end
    end
    send_byte(CH_NUL);

    // Let the last tokens drain, then wait quietly for stragglers.
    in_tvalid <= 1'b0;
    @(posedge clk);
    while (sb.pending() != 0) @(posedge clk);
    repeat (10) @(posedge clk);

    $display("Lexed %0d bytes into %0d checked tokens covering %0d of 11 token kinds,",
             bytes_taken, sb.checked, sb.kinds_seen());
    $display("with unterminated strings and comments, stalls on both sides and a drain.");
    if (sb.errors == 0) begin
      $display("[ OK ] regression clean");
    end else begin
      $display("[FAIL] regression broken");
    end
    $finish;
  end

endmodule

>>> files.f
rtl/lsplex_pkg.sv
rtl/lsplex_scan.sv
rtl/lsplex_outq.sv
rtl/lisp_token_lexer.sv
sim/lisp_token_lexer_tb.sv
